// ===== rtl/core/lfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfd_pkg: shared constants and types for the LED frame-stream decoder
// Holds protocol bytes, register indexes, command codes and the result record.
// ----------------------------------------------------------------------------
package lfd_pkg;

	// Header protocol bytes
	localparam logic [7:0] MAGIC0    = 8'h41;   // 'A'
	localparam logic [7:0] MAGIC1    = 8'h64;   // 'd'
	localparam logic [7:0] MAGIC2    = 8'h61;   // 'a'
	localparam logic [7:0] CHECK_XOR = 8'h55;

	// Pixel geometry
	localparam int unsigned LED_COUNT = 256;
	localparam int unsigned PIX_W     = $clog2(LED_COUNT + 1);
	localparam logic [PIX_W-1:0] LED_LIMIT = PIX_W'(LED_COUNT);

	// Byte positions inside the header
	localparam logic [2:0] POS_HIGH  = 3'd3;
	localparam logic [2:0] POS_LOW   = 3'd4;
	localparam logic [2:0] POS_CHECK = 3'd5;
	// Last color channel inside a pixel
	localparam logic [2:0] POS_LAST_CH = 3'd2;

	// Reset values of the configuration registers
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;
	localparam logic [7:0]  TIMEOUT_LIMIT_RST = 8'd10;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_LEDS_ENABLED  = 2'd0,
		REG_TIMEOUT_TICKS = 2'd1,
		REG_TIMEOUT_LIMIT = 2'd2
	} reg_index_t;

	// Input command kinds
	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_TICK = 1'b1
	} command_t;

	// One result item
	typedef struct packed {
		logic       leds_off;
		logic       send_ping;
		logic       show_leds;
		logic       clear_leds;
		logic [7:0] color_value;
		logic [1:0] color_channel;
		logic [7:0] pixel_index;
		logic       pixel_write;
	} result_t;

endpackage

// ===== rtl/core/led_stream_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// led_stream_frame_decoder_core: serial LED frame-stream decoder
// Parses header and pixel bytes, counts idle ticks, emits one result per item.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                    | payload
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: data_byte; tuser: command
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: result record
//  cfg       | in        | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
//  One item per cycle while the result side does not stall; its result is written
//  into the result register at the edge that takes the input transaction. Parser
//  and timeout state update in that same edge, so the next item sees them at once.
//  The input side stays ready while the result register is empty or is being
//  drained; a stalled result blocks only new input transactions.
//  arst_n resets parser, counters, config and valid, not the count bytes or payload.
//  Configuration writes are always accepted.
module led_stream_frame_decoder_core
	import lfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] command
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [0] pixel_write, [8:1] pixel_index,
	                                    // [10:9] color_channel, [18:11] color_value,
	                                    // [19] clear_leds, [20] show_leds,
	                                    // [21] send_ping, [22] leds_off, [23] zero
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers
	logic        leds_enabled_q;
	logic [15:0] timeout_ticks_q;
	logic [7:0]  timeout_limit_q;

	// Parser and timeout state
	logic             in_data_mode_q;
	logic [2:0]       byte_position_q;
	logic [7:0]       count_high_q;
	logic [7:0]       count_low_q;
	logic [16:0]      pixels_remaining_q;
	logic [PIX_W-1:0] current_pixel_q;
	logic [15:0]      idle_ticks_q;
	logic [7:0]       ping_count_q;

	// Next-state values
	logic             in_data_mode_d;
	logic [2:0]       byte_position_d;
	logic [7:0]       count_high_d;
	logic [7:0]       count_low_d;
	logic [16:0]      pixels_remaining_d;
	logic [PIX_W-1:0] current_pixel_d;
	logic [15:0]      idle_ticks_d;
	logic [7:0]       ping_count_d;

	result_t result_d;
	result_t result_q;
	logic    out_valid_q;
	logic    in_accept;

	logic [7:0]  magic_byte;
	logic [15:0] ticks_inc;
	logic [7:0]  pings_inc;
	logic        pixel_in_range;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, result_q};

	// Store configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leds_enabled_q  <= 1'b0;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
			timeout_limit_q <= TIMEOUT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEDS_ENABLED:  leds_enabled_q  <= cfg_data[0];
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				REG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Pick the expected magic byte for the header position
	always_comb begin
		case (byte_position_q)
			3'd0:    magic_byte = MAGIC0;
			3'd1:    magic_byte = MAGIC1;
			default: magic_byte = MAGIC2;
		endcase
	end

	assign ticks_inc      = (idle_ticks_q == 16'hFFFF) ? idle_ticks_q : idle_ticks_q + 16'd1;
	assign pings_inc      = (ping_count_q < timeout_limit_q) ? ping_count_q + 8'd1
	                                                          : ping_count_q;
	assign pixel_in_range = current_pixel_q < LED_LIMIT;

	// Decode one item: parser step or timeout step
	always_comb begin
		in_data_mode_d     = in_data_mode_q;
		byte_position_d    = byte_position_q;
		count_high_d       = count_high_q;
		count_low_d        = count_low_q;
		pixels_remaining_d = pixels_remaining_q;
		current_pixel_d    = current_pixel_q;
		idle_ticks_d       = idle_ticks_q;
		ping_count_d       = ping_count_q;
		result_d           = '0;

		if (s_axis_tuser == CMD_BYTE) begin
			idle_ticks_d = '0;
			ping_count_d = '0;
			if (in_data_mode_q) begin
				// Pixel channel byte
				if (leds_enabled_q && pixel_in_range) begin
					result_d.pixel_write   = 1'b1;
					result_d.pixel_index   = current_pixel_q[7:0];
					result_d.color_channel = byte_position_q[1:0];
					result_d.color_value   = s_axis_tdata;
				end
				if (byte_position_q >= POS_LAST_CH) begin
					byte_position_d = '0;
					if (pixel_in_range)
						current_pixel_d = current_pixel_q + 1'b1;
					if (pixels_remaining_q != '0)
						pixels_remaining_d = pixels_remaining_q - 17'd1;
				end else begin
					byte_position_d = byte_position_q + 3'd1;
				end
				// Frame done: show if enabled and return to header mode
				if (pixels_remaining_d == '0) begin
					result_d.show_leds = leds_enabled_q;
					byte_position_d    = '0;
					in_data_mode_d     = 1'b0;
				end
			end else begin
				// Header byte
				if (byte_position_q < POS_HIGH) begin
					byte_position_d = (s_axis_tdata == magic_byte) ? byte_position_q + 3'd1
					                                               : 3'd0;
				end else if (byte_position_q == POS_HIGH) begin
					count_high_d    = s_axis_tdata;
					byte_position_d = POS_LOW;
				end else if (byte_position_q == POS_LOW) begin
					count_low_d     = s_axis_tdata;
					byte_position_d = POS_CHECK;
				end else begin
					if (byte_position_q == POS_CHECK &&
					    (count_high_q ^ count_low_q ^ CHECK_XOR) == s_axis_tdata) begin
						current_pixel_d     = '0;
						pixels_remaining_d  = {1'b0, count_high_q, count_low_q} + 17'd1;
						in_data_mode_d      = 1'b1;
						result_d.clear_leds = 1'b1;
					end
					byte_position_d = '0;
				end
			end
		end else begin
			// Idle tick: count, ping, and reset the parser at the limit
			idle_ticks_d = ticks_inc;
			if (ticks_inc >= timeout_ticks_q) begin
				result_d.send_ping = 1'b1;
				idle_ticks_d       = '0;
				ping_count_d       = pings_inc;
				if (pings_inc == timeout_limit_q) begin
					in_data_mode_d     = 1'b0;
					byte_position_d    = '0;
					pixels_remaining_d = '0;
					current_pixel_d    = '0;
					result_d.leds_off  = 1'b1;
				end
			end
		end
	end

	// Advance state on each input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_data_mode_q     <= 1'b0;
			byte_position_q    <= '0;
			pixels_remaining_q <= '0;
			current_pixel_q    <= '0;
			idle_ticks_q       <= '0;
			ping_count_q       <= '0;
			out_valid_q        <= 1'b0;
		end else begin
			if (in_accept) begin
				in_data_mode_q     <= in_data_mode_d;
				byte_position_q    <= byte_position_d;
				pixels_remaining_q <= pixels_remaining_d;
				current_pixel_q    <= current_pixel_d;
				idle_ticks_q       <= idle_ticks_d;
				ping_count_q       <= ping_count_d;
				out_valid_q        <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold count bytes and the result payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			count_high_q <= count_high_d;
			count_low_q  <= count_low_d;
			result_q     <= result_d;
		end
	end

	// Checks on decoder state and result
	a_pixel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		current_pixel_q <= LED_LIMIT)
		else $error("current pixel beyond LED count");

	a_data_position: assert property (@(posedge clk) disable iff (!arst_n)
		in_data_mode_q |-> byte_position_q <= POS_LAST_CH)
		else $error("channel position out of range in data mode");

	a_unused_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !result_q.pixel_write) |->
		(result_q.pixel_index == '0 && result_q.color_channel == '0 &&
		 result_q.color_value == '0))
		else $error("pixel fields set without a pixel write");

	a_clear_show: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(result_q.clear_leds && result_q.show_leds))
		else $error("clear and show in the same result");

	a_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && s_axis_tuser == CMD_TICK) |=>
		(!result_q.pixel_write && !result_q.clear_leds && !result_q.show_leds))
		else $error("tick produced a frame result");

endmodule

// ===== tb/tb_led_stream_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_led_stream_frame_decoder_core: self-checking bench for the frame decoder
// Drives serial bytes and idle ticks into the input stream, predicts
// every result record with a cycle-free model of the parser and idle timer,
// and compares each output transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_led_stream_frame_decoder_core;
	import lfd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_ITEMS = 30;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// Predicted decoder state and register copies
	logic        mdl_enabled;
	logic [15:0] mdl_timeout_ticks;
	logic [7:0]  mdl_timeout_limit;
	logic        mdl_data_mode;
	logic [2:0]  mdl_pos;
	logic [7:0]  mdl_count_hi;
	logic [7:0]  mdl_count_lo;
	logic [16:0] mdl_pixels_left;
	logic [PIX_W-1:0] mdl_pixel;
	logic [15:0] mdl_idle_ticks;
	logic [7:0]  mdl_pings;

	result_t     expected_results[$];
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;
	bit          idle_on = 1'b1;
	int unsigned rx_hold = 0;
	int unsigned rx_stall_left = 0;

	led_stream_frame_decoder_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Clock: period 20
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("led_stream_frame_decoder_core test failed");
			$finish;
		end
	end

	// Advance the predicted parser and timer by one item, return its result
	function automatic result_t decode_item(command_t cmd, logic [7:0] b);
		result_t    r;
		logic [7:0] magic_byte;
		r = '0;
		if (cmd == CMD_BYTE) begin
			mdl_idle_ticks = '0;
			mdl_pings = '0;
			if (mdl_data_mode) begin
				if (mdl_enabled && mdl_pixel < LED_LIMIT) begin
					r.pixel_write   = 1'b1;
					r.pixel_index   = mdl_pixel[7:0];
					r.color_channel = mdl_pos[1:0];
					r.color_value   = b;
				end
				mdl_pos = mdl_pos + 3'd1;
				if (mdl_pos > POS_LAST_CH) begin
					mdl_pos = '0;
					if (mdl_pixel < LED_LIMIT)
						mdl_pixel = mdl_pixel + 1'b1;
					if (mdl_pixels_left != '0)
						mdl_pixels_left = mdl_pixels_left - 17'd1;
				end
				if (mdl_pixels_left == '0) begin
					r.show_leds = mdl_enabled;
					mdl_pos = '0;
					mdl_data_mode = 1'b0;
				end
			end else begin
				magic_byte = (mdl_pos == 3'd0) ? MAGIC0 : (mdl_pos == 3'd1) ? MAGIC1 : MAGIC2;
				if (mdl_pos < POS_HIGH) begin
					mdl_pos = (b == magic_byte) ? mdl_pos + 3'd1 : 3'd0;
				end else if (mdl_pos == POS_HIGH) begin
					mdl_count_hi = b;
					mdl_pos = POS_LOW;
				end else if (mdl_pos == POS_LOW) begin
					mdl_count_lo = b;
					mdl_pos = POS_CHECK;
				end else if (mdl_pos == POS_CHECK) begin
					if ((mdl_count_hi ^ mdl_count_lo ^ CHECK_XOR) == b) begin
						mdl_pixel = '0;
						mdl_pixels_left = {1'b0, mdl_count_hi, mdl_count_lo} + 17'd1;
						mdl_data_mode = 1'b1;
						r.clear_leds = 1'b1;
					end
					mdl_pos = '0;
				end else begin
					mdl_pos = '0;
				end
			end
		end else begin
			if (mdl_idle_ticks != 16'hFFFF)
				mdl_idle_ticks = mdl_idle_ticks + 16'd1;
			if (mdl_idle_ticks >= mdl_timeout_ticks) begin
				r.send_ping = 1'b1;
				mdl_idle_ticks = '0;
				if (mdl_pings < mdl_timeout_limit)
					mdl_pings = mdl_pings + 8'd1;
				if (mdl_pings == mdl_timeout_limit) begin
					mdl_data_mode = 1'b0;
					mdl_pos = '0;
					mdl_pixels_left = '0;
					mdl_pixel = '0;
					r.leds_off = 1'b1;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned exp);
		$display("result %0d: %s got %0d, expected %0d", results_seen, what, got, exp);
		errors++;
	endtask

	// Drive the result-side ready: long hold-offs, random stall bursts
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else if (rx_stall_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			rx_stall_left = $urandom_range(1, 5) - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Check each result transaction against the oldest prediction
	always @(negedge clk) begin
		result_t got;
		result_t exp;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[22:0]);
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected transaction, pending count", 0, 0);
			end else begin
				exp = expected_results.pop_front();
				if (got.pixel_write !== exp.pixel_write)
					report_mismatch("pixel_write", got.pixel_write, exp.pixel_write);
				if (got.pixel_index !== exp.pixel_index)
					report_mismatch("pixel_index", got.pixel_index, exp.pixel_index);
				if (got.color_channel !== exp.color_channel)
					report_mismatch("color_channel", got.color_channel, exp.color_channel);
				if (got.color_value !== exp.color_value)
					report_mismatch("color_value", got.color_value, exp.color_value);
				if (got.clear_leds !== exp.clear_leds)
					report_mismatch("clear_leds", got.clear_leds, exp.clear_leds);
				if (got.show_leds !== exp.show_leds)
					report_mismatch("show_leds", got.show_leds, exp.show_leds);
				if (got.send_ping !== exp.send_ping)
					report_mismatch("send_ping", got.send_ping, exp.send_ping);
				if (got.leds_off !== exp.leds_off)
					report_mismatch("leds_off", got.leds_off, exp.leds_off);
				if (m_axis_tdata[23] !== 1'b0)
					report_mismatch("pad bit", m_axis_tdata[23], 0);
			end
			results_seen++;
		end
	end

	// Offer one item, hold it until the transaction, then predict its result
	task automatic send_item(command_t cmd, logic [7:0] b);
		bit taken;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= b;
		do begin
			@(negedge clk);
			taken = s_axis_tready;
			@(posedge clk);
		end while (!taken);
		expected_results.push_back(decode_item(cmd, b));
		items_sent++;
	endtask

	// Stop offering input and wait until every result has drained
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write one register while the block is idle
	task automatic cfg_write(reg_index_t idx, logic [15:0] value);
		bit taken;
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LEDS_ENABLED:  mdl_enabled = value[0];
			REG_TIMEOUT_TICKS: mdl_timeout_ticks = value;
			REG_TIMEOUT_LIMIT: mdl_timeout_limit = value[7:0];
			default: ;
		endcase
	endtask

	// Send a header and, if the check is good, up to data_limit data bytes; ticks slip in at random
	task automatic send_frame(logic [7:0] hi, logic [7:0] lo, bit check_ok,
	                          int unsigned data_limit, int unsigned tick_one_in);
		logic [7:0]  chk;
		int unsigned n_data;
		chk = hi ^ lo ^ CHECK_XOR;
		if (!check_ok)
			chk = chk ^ 8'($urandom_range(1, 255));
		send_item(CMD_BYTE, MAGIC0);
		send_item(CMD_BYTE, MAGIC1);
		send_item(CMD_BYTE, MAGIC2);
		send_item(CMD_BYTE, hi);
		send_item(CMD_BYTE, lo);
		send_item(CMD_BYTE, chk);
		if (check_ok) begin
			n_data = ({hi, lo} + 1) * 3;
			if (n_data > data_limit)
				n_data = data_limit;
			for (int unsigned i = 0; i < n_data; i++) begin
				if (tick_one_in != 0 && $urandom_range(1, tick_one_in) == 1)
					send_item(CMD_TICK, 8'($urandom()));
				send_item(CMD_BYTE, 8'($urandom()));
			end
		end
	endtask

	// Header, one-pixel frame, magic errors, bad checksum, pings and timeouts
	task automatic test_directed();
		cfg_write(REG_LEDS_ENABLED, 16'd1);
		cfg_write(REG_TIMEOUT_TICKS, 16'd2);
		cfg_write(REG_TIMEOUT_LIMIT, 16'd2);
		send_item(CMD_BYTE, MAGIC0);
		send_item(CMD_BYTE, MAGIC1);
		send_item(CMD_BYTE, MAGIC2);
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_BYTE, CHECK_XOR);
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_BYTE, 8'hFF);
		send_item(CMD_BYTE, 8'h80);
		// a repeated first byte is not retried as a new start
		send_item(CMD_BYTE, MAGIC0);
		send_item(CMD_BYTE, MAGIC0);
		send_item(CMD_BYTE, MAGIC1);
		send_frame(8'h12, 8'h34, 1'b0, 0, 0);
		// two pings reach the limit, a third stays saturated
		repeat (6) send_item(CMD_TICK, 8'hFF);
		send_item(CMD_BYTE, 8'h00);
	endtask

	// Data parsed but writes and shows suppressed
	task automatic test_leds_disabled();
		cfg_write(REG_LEDS_ENABLED, 16'd0);
		send_frame(8'h00, 8'h01, 1'b1, 6, 0);
		cfg_write(REG_LEDS_ENABLED, 16'd1);
	endtask

	// More pixels than LEDs: writes stop past the last index
	task automatic test_pixel_overflow();
		send_frame(8'h01, 8'h01, 1'b1, 1000, 0);
	endtask

	// Largest header cut short by the idle timeout, then a clean frame
	task automatic test_timeout_in_frame();
		cfg_write(REG_TIMEOUT_TICKS, 16'd1);
		cfg_write(REG_TIMEOUT_LIMIT, 16'd1);
		send_frame(8'hFF, 8'hFF, 1'b1, 10, 0);
		send_item(CMD_TICK, 8'h00);
		send_frame(8'h00, 8'h00, 1'b1, 3, 0);
	endtask

	// Ping count saturates at the limit
	task automatic test_ping_saturation();
		cfg_write(REG_TIMEOUT_LIMIT, 16'd40);
		repeat (44) send_item(CMD_TICK, 8'($urandom()));
		send_item(CMD_BYTE, 8'h00);
	endtask

	// Longest timeout: ticks alone raise nothing
	task automatic test_timeout_max();
		cfg_write(REG_TIMEOUT_TICKS, 16'hFFFF);
		repeat (4) send_item(CMD_TICK, 8'h00);
		send_item(CMD_BYTE, 8'h55);
	endtask

	// Hold the result side off while input is offered, so the input side stalls
	task automatic test_backpressure();
		cfg_write(REG_TIMEOUT_TICKS, 16'd3);
		cfg_write(REG_TIMEOUT_LIMIT, 16'd2);
		rx_hold = 64;
		send_frame(8'h00, 8'h05, 1'b1, 18, 4);
		repeat (10) send_item(CMD_TICK, 8'h00);
	endtask

	// Random phases of mostly well-formed frames mixed with noise and ticks
	task automatic test_random();
		int unsigned phase_start;
		int unsigned pick;
		for (int phase = 0; phase < 5; phase++) begin
			idle_on = (phase != 4);
			cfg_write(REG_LEDS_ENABLED, (phase == 0) ? 16'd0 : 16'($urandom_range(0, 1)));
			pick = $urandom_range(0, 9);
			cfg_write(REG_TIMEOUT_TICKS, (pick == 0) ? 16'hFFFF :
			                             (pick < 3) ? 16'd1 : 16'($urandom_range(2, 8)));
			pick = $urandom_range(0, 9);
			cfg_write(REG_TIMEOUT_LIMIT, (pick == 0) ? 16'd255 :
			                             (pick < 3) ? 16'd1 : 16'($urandom_range(2, 5)));
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					send_frame(8'h00, 8'($urandom_range(0, 4)), 1'b1, 1000, 20);
				else if (pick == 6)
					send_frame(8'($urandom()), 8'($urandom()), 1'b0, 0, 0);
				else if (pick == 7)
					repeat ($urandom_range(1, 4)) send_item(CMD_BYTE, 8'($urandom()));
				else
					repeat ($urandom_range(1, 8)) send_item(CMD_TICK, 8'($urandom()));
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_BYTE;
		cfg_valid     = 1'b0;
		cfg_index     = REG_LEDS_ENABLED;
		cfg_data      = '0;
		mdl_enabled       = 1'b0;
		mdl_timeout_ticks = TIMEOUT_TICKS_RST;
		mdl_timeout_limit = TIMEOUT_LIMIT_RST;
		mdl_data_mode     = 1'b0;
		mdl_pos           = '0;
		mdl_count_hi      = '0;
		mdl_count_lo      = '0;
		mdl_pixels_left   = '0;
		mdl_pixel         = '0;
		mdl_idle_ticks    = '0;
		mdl_pings         = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_leds_disabled();
		test_pixel_overflow();
		test_timeout_in_frame();
		test_ping_saturation();
		test_timeout_max();
		test_backpressure();
		test_random();

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("led_stream_frame_decoder_core test passed");
		end else begin
			$display("led_stream_frame_decoder_core test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/lfd_pkg.sv
rtl/core/led_stream_frame_decoder_core.sv
tb/tb_led_stream_frame_decoder_core.sv
